@@ hw/rtl/pidta_pkg.sv @@
// ----------------------------------------------------------------------------
// pidta_pkg
// Shared constants, codes and saturation helpers for the PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidta_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic FN_EVAL  = 1'b0;
  localparam logic FN_CLEAR = 1'b1;

  localparam logic [1:0] FRZ_UP   = 2'd1;
  localparam logic [1:0] FRZ_DOWN = 2'd2;

  localparam logic [1:0] SAT_NONE = 2'd0;
  localparam logic [1:0] SAT_HIGH = 2'd1;
  localparam logic [1:0] SAT_LOW  = 2'd2;

  localparam logic [2:0] REG_KC   = 3'd0;
  localparam logic [2:0] REG_TI   = 3'd1;
  localparam logic [2:0] REG_TD   = 3'd2;
  localparam logic [2:0] REG_N    = 3'd3;
  localparam logic [2:0] REG_WP   = 3'd4;
  localparam logic [2:0] REG_WD   = 3'd5;
  localparam logic [2:0] REG_OMIN = 3'd6;
  localparam logic [2:0] REG_OMAX = 3'd7;

  localparam logic signed [31:0] S32MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32MIN = 32'sh80000000;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = S32MAX;
    end else if (v < -66'sd2147483648) begin
      r = S32MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [65:0] sx64(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pid_with_tracking_antiwindup.sv @@
// ----------------------------------------------------------------------------
// pid_with_tracking_antiwindup
// Two-degree-of-freedom PID with filtered derivative and tracking anti-windup.
// ----------------------------------------------------------------------------
// One step per input transaction. s_tuser = func (1 clears stored history).
// s_tdata carries measurement, setpoint, sample time, track value, tracking
// and freeze code; m_tdata returns the clamped drive and saturation status.
// Coefficients and products go through one shared bit-serial multiplier
// (issue, shift-add iterations, capture) and one bit-serial restoring
// divider (issue, subtract-shift iterations, capture), sequenced step by step.
// An evaluate step takes 10 products and 2 quotients (Ti zero skips the
// first quotient; Td zero skips 3 products and 1 quotient); a clear step
// skips the serial units and goes straight to writing its result. s_tready
// returns in the cycle after the result is written, so no new item is
// accepted before the last one is written. The next item is accepted even
// while the last result waits in the output register. If the receiver
// stalls, the finished result is held and the sequencer waits before
// writing the next one. Reset clears the stored history and sets registers
// to their defaults (limits fully open). The config channel is always ready;
// the user must write it only while the block is idle; this is not enforced.
`default_nettype none

module pid_with_tracking_antiwindup (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [31:0] measured, [63:32] setpoint, [94:64] sample_time,
  // [126:95] track_value, [127] tracking, [129:128] freeze_mode, rest zero
  input  wire logic [135:0] s_tdata,
  // [0] func
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [31:0] drive, [33:32] sat_status, rest zero
  output logic [39:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import pidta_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_RUN, ST_CAP, ST_FIN
  } state_t;

  state_t state;
  logic [3:0] step;
  logic       clr;

  // configuration
  logic [30:0] kc, ti, td, nf;
  logic signed [31:0] wp, wd, omin, omax;

  // latched input
  logic signed [31:0] y, ysp, trk;
  logic [30:0] dt;
  logic trkmode;
  logic [1:0] frz;

  // history
  logic signed [31:0] prev_y, prev_sp, prev_u, integ, deriv;
  logic [1:0] sat_flag;

  // intermediates
  logic [63:0] p1, den;
  logic [31:0] a1, b1, nb;
  logic signed [31:0] b2, t2, t3, pterm;
  logic signed [63:0] m1, ai;

  // serial units
  logic        is_div;
  logic [6:0]  cnt;
  logic signed [63:0] mc, acc;
  logic [31:0] mp;
  logic [63:0] rem, dvd, dvs, quo;

  logic [30:0] keff;
  logic signed [31:0] e, dsp, dy;
  logic [64:0] rsh;
  logic signed [63:0] prod_asr;

  assign keff = (kc == '0) ? 31'(1 << FRAC_BITS) : kc;
  assign e    = sat32(sx32(ysp) - sx32(y));
  assign dsp  = sat32(sx32(ysp) - sx32(prev_sp));
  assign dy   = sat32(sx32(y) - sx32(prev_y));
  assign rsh  = {rem, dvd[63]};
  assign prod_asr = acc >>> FRAC_BITS;

  // final combine
  logic signed [31:0] u_auto, u0, u_fin, i_fin;
  logic [1:0] st_fin;
  logic hold;

  always_comb begin
    u_auto = sat32(sx32(pterm) + sx32(integ) + sx32(deriv));
    u0     = trkmode ? trk : u_auto;
    u_fin  = u0;
    st_fin = SAT_NONE;
    hold   = 1'b0;
    i_fin  = integ;
    if (u0 > omax) begin
      u_fin  = omax;
      st_fin = SAT_HIGH;
    end else if (u0 < omin) begin
      u_fin  = omin;
      st_fin = SAT_LOW;
    end else begin
      if (trkmode) begin
        hold = 1'b1;
      end else if (frz == FRZ_UP && u0 > prev_u) begin
        u_fin = prev_u;
        hold  = 1'b1;
      end else if (frz == FRZ_DOWN && u0 < prev_u) begin
        u_fin = prev_u;
        hold  = 1'b1;
      end
      if (hold) begin
        i_fin = sat32(sx32(u_fin) - sx32(pterm) - sx32(deriv));
      end else begin
        i_fin = sat32(sx32(integ) + sx64(ai));
      end
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      clr <= 1'b0;
      m_tvalid <= 1'b0;
      kc <= '0; ti <= '0; td <= '0; nf <= '0;
      wp <= '0; wd <= '0; omin <= S32MIN; omax <= S32MAX;
      prev_y <= '0; prev_sp <= '0; prev_u <= '0; integ <= '0; deriv <= '0;
      sat_flag <= SAT_NONE;
    end else begin
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_KC:   kc <= cfg_data[30:0];
          REG_TI:   ti <= cfg_data[30:0];
          REG_TD:   td <= cfg_data[30:0];
          REG_N:    nf <= cfg_data[30:0];
          REG_WP:   wp <= cfg_data;
          REG_WD:   wd <= cfg_data;
          REG_OMIN: omin <= cfg_data;
          REG_OMAX: omax <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            y       <= s_tdata[31:0];
            ysp     <= s_tdata[63:32];
            dt      <= s_tdata[94:64];
            trk     <= s_tdata[126:95];
            trkmode <= s_tdata[127];
            frz     <= s_tdata[129:128];
            clr     <= (s_tuser == FN_CLEAR);
            step    <= '0;
            state   <= (s_tuser == FN_CLEAR) ? ST_FIN : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          cnt    <= '0;
          is_div <= (step == 4'd3) || (step == 4'd1 && ti != '0);
          acc    <= '0;
          case (step)
            4'd0: begin mc <= 64'(keff); mp <= {1'b0, dt}; state <= ST_RUN; end
            4'd1: begin
              if (ti == '0) begin
                a1 <= '0; step <= 4'd2;
              end else begin
                dvd <= p1; dvs <= 64'(ti); rem <= '0; state <= ST_RUN;
              end
            end
            4'd2: begin
              if (td == '0) begin
                b1 <= '0; b2 <= '0; step <= 4'd6;
              end else begin
                mc <= 64'(nf); mp <= {1'b0, dt}; state <= ST_RUN;
              end
            end
            4'd3: begin
              dvd <= 64'(td) << FRAC_BITS; dvs <= den; rem <= '0; state <= ST_RUN;
            end
            4'd4: begin mc <= 64'(nf); mp <= b1; state <= ST_RUN; end
            4'd5: begin mc <= 64'(keff); mp <= nb; state <= ST_RUN; end
            // signed multiplicands are sign-extended
            4'd6: begin mc <= {{32{wd[31]}}, wd}; mp <= dsp; state <= ST_RUN; end
            4'd7: begin mc <= 64'(b1); mp <= deriv; state <= ST_RUN; end
            4'd8: begin mc <= {{32{b2[31]}}, b2}; mp <= t2; state <= ST_RUN; end
            4'd9: begin mc <= {{32{wp[31]}}, wp}; mp <= ysp; state <= ST_RUN; end
            4'd10: begin mc <= 64'({1'b0, kc}); mp <= t3; state <= ST_RUN; end
            4'd11: begin mc <= 64'(a1); mp <= e; state <= ST_RUN; end
            default: state <= ST_FIN;
          endcase
        end
        ST_RUN: begin
          cnt <= cnt + 7'd1;
          if (is_div) begin
            dvd <= {dvd[62:0], 1'b0};
            if (rsh >= {1'b0, dvs}) begin
              rem <= 64'(rsh - {1'b0, dvs});
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rsh[63:0];
              quo <= {quo[62:0], 1'b0};
            end
            if (cnt == 7'd63) begin
              state <= ST_CAP;
            end
          end else begin
            if (mp[0]) begin
              acc <= (cnt == 7'd31) ? acc - mc : acc + mc;
            end
            mc <= mc <<< 1;
            mp <= mp >> 1;
            if (cnt == 7'd31) begin
              state <= ST_CAP;
            end
          end
        end
        ST_CAP: begin
          step <= step + 4'd1;
          case (step)
            4'd0: begin p1 <= acc; state <= ST_ISSUE; end
            4'd1: begin
              a1 <= (quo > 64'(S32MAX)) ? S32MAX : quo[31:0];
              state <= ST_ISSUE;
            end
            4'd2: begin den <= 64'(acc[62:FRAC_BITS]) + 64'(td); state <= ST_ISSUE; end
            4'd3: begin b1 <= quo[31:0]; state <= ST_ISSUE; end
            4'd4: begin nb <= 32'(acc[62:FRAC_BITS]); state <= ST_ISSUE; end
            4'd5: begin b2 <= sat32(sx64(64'(acc[62:FRAC_BITS]))); state <= ST_ISSUE; end
            4'd6: begin
              t2 <= sat32(sx32(sat32(sx64(prod_asr))) - sx32(dy));
              state <= ST_ISSUE;
            end
            4'd7: begin m1 <= prod_asr; state <= ST_ISSUE; end
            4'd8: begin deriv <= sat32(sx64(m1) + sx64(prod_asr)); state <= ST_ISSUE; end
            4'd9: begin
              t3 <= sat32(sx32(sat32(sx64(prod_asr))) - sx32(y));
              state <= ST_ISSUE;
            end
            4'd10: begin pterm <= sat32(sx64(prod_asr)); state <= ST_ISSUE; end
            4'd11: begin ai <= prod_asr; state <= ST_FIN; end
            default: state <= ST_FIN;
          endcase
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            if (clr) begin
              m_tdata  <= {6'd0, sat_flag, 32'd0};
              prev_y <= '0; prev_sp <= '0; prev_u <= '0;
              integ <= '0; deriv <= '0;
            end else begin
              m_tdata  <= {6'd0, st_fin, u_fin};
              sat_flag <= st_fin;
              integ    <= i_fin;
              prev_y   <= y;
              prev_sp  <= ysp;
              prev_u   <= u_fin;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
